@@ rtl/thread_ready_wait_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Thread scheduler assertion macros
// Small wrappers for the concurrent checks of the scheduler top level.
// ----------------------------------------------------------------------------
`ifndef THREAD_READY_WAIT_SCHEDULER_ASSERT_SVH
`define THREAD_READY_WAIT_SCHEDULER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define TRWS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("scheduler check failed");

// When the antecedent holds, the consequent holds at the same edge.
`define TRWS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

`endif

@@ rtl/trws_pkg.sv @@
// ----------------------------------------------------------------------------
// Thread scheduler package
// Shared constants, operation and status codes, sequencer states and the
// result record of the thread scheduler.
// ----------------------------------------------------------------------------
package trws_pkg;

    localparam int DEFAULT_SLOTS = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int SENT_W        = $clog2(MAX_RESULTS);
    localparam int SLEEP_W       = 16;

    // Byte that stands for "no character".
    localparam logic [7:0] NO_CHAR = 8'h23;

    localparam logic [2:0] FUNC_CREATE = 3'd0;
    localparam logic [2:0] FUNC_TICK   = 3'd1;
    localparam logic [2:0] FUNC_WAIT   = 3'd2;
    localparam logic [2:0] FUNC_KILL   = 3'd3;
    localparam logic [2:0] FUNC_CHAR   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_NO_CHAR = 2'd2;
    localparam logic [1:0] ST_NO_RUN  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CR,
        S_O0,
        S_O1,
        S_WT0,
        S_WT1,
        S_KS1,
        S_KS2,
        S_KS3,
        S_T0,
        S_T1,
        S_T2,
        S_SW0,
        S_SW1,
        S_SW2,
        S_SWN,
        S_SWEND,
        S_C1,
        S_C2,
        S_W0,
        S_W1,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_EM,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic       running_valid;
        logic [4:0] running_id;
        logic       switched;
        logic [4:0] created_id;
        logic       woken_valid;
        logic [4:0] woken_id;
        logic [7:0] delivered_char;
        logic [5:0] ready_count;
        logic [5:0] waiting_count;
        logic       last_result;
    } result_t;

endpackage

@@ rtl/trws_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module trws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/thread_ready_wait_scheduler.sv @@
// ----------------------------------------------------------------------------
// Thread scheduler
// Round-robin thread scheduler with a ready ring and a waiting ring kept
// as linked lists in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage: one transaction on the s_ channel is one scheduler event (create,
// tick, wait, kill, character). Each event returns one or more result
// transactions on the m_ channel; m_last_result marks the final one. A tick
// or a kill sweep returns one result per thread woken.
// Events are handled one at a time; s_ready is high only when the sequencer
// is idle. A create scans the in-use bits one slot a cycle. Killing the last
// ready thread scans the waiting entries, and runs a tick sweep when a
// sleeper is due. A tick rotates the ready ring and walks the waiting ring;
// a character event searches the waiting ring for a thread waiting for a
// character. Every step is one access to the link and sleep RAMs, whose
// read data is registered. A result is held in a pending register until
// the next one, or the end of the event, is known; when the receiver
// stalls m_ready, the sequencer waits in place and the output holds.
// Reset empties both rings and frees all slots at once; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module thread_ready_wait_scheduler #(
    parameter int SLOTS = trws_pkg::DEFAULT_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_sleep_ticks,
    input  logic [7:0]  s_char_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_running_valid,
    output logic [4:0]  m_running_id,
    output logic        m_switched,
    output logic [4:0]  m_created_id,
    output logic        m_woken_valid,
    output logic [4:0]  m_woken_id,
    output logic [7:0]  m_delivered_char,
    output logic [5:0]  m_ready_count,
    output logic [5:0]  m_waiting_count,
    output logic        m_last_result
);

    localparam int LW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = trws_pkg::SLEEP_W;
    localparam logic [trws_pkg::SENT_W-1:0] SENT_CAP =
        trws_pkg::SENT_W'(trws_pkg::MAX_RESULTS - 1);

    trws_pkg::state_t state_reg, state_next;
    logic [LW-1:0]  rh_reg, rh_next, rt_reg, rt_next;
    logic [LW-1:0]  wh_reg, wh_next, wt_reg, wt_next;
    logic [CW-1:0]  rcnt_reg, rcnt_next, wcnt_reg, wcnt_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [LW-1:0]  cur_reg, cur_next, nx_reg, nx_next;
    logic [CW-1:0]  idx_reg, idx_next, lim_reg, lim_next;
    logic           due_reg, due_next, woke_reg, woke_next;
    logic           in_sweep_reg, in_sweep_next;
    logic [2:0]     op_reg, op_next;
    logic [SW-1:0]  ticks_reg, ticks_next;
    logic [7:0]     ch_reg, ch_next;
    logic [1:0]     e_status_reg, e_status_next;
    logic [LW-1:0]  e_created_reg, e_created_next;
    logic           e_wv_reg, e_wv_next;
    logic [LW-1:0]  e_wid_reg, e_wid_next;
    logic [7:0]     e_ch_reg, e_ch_next;
    logic           prev_v_reg, prev_v_next;
    logic [LW-1:0]  prev_id_reg, prev_id_next;
    logic [trws_pkg::SENT_W-1:0] sent_reg, sent_next;
    trws_pkg::result_t pend_reg, pend_next, out_reg, out_next, new_res;
    logic           pend_v_reg, pend_v_next;
    logic           m_valid_reg, m_valid_next;

    logic           nl_we, pl_we, sl_we;
    logic [LW-1:0]  nl_wa, nl_wd, pl_wa, pl_wd, sl_wa;
    logic [SW-1:0]  sl_wd;
    logic [LW-1:0]  nl_ra, pl_ra, sl_ra;
    logic [LW-1:0]  nl_rd, pl_rd;
    logic [SW-1:0]  sl_rd;

    logic           out_free;
    logic           rv;
    logic [LW-1:0]  rid;
    logic [CW:0]    ring_sum;

    trws_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
        .aclk(aclk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
        .raddr(nl_ra), .rdata(nl_rd)
    );

    trws_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
        .aclk(aclk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
        .raddr(pl_ra), .rdata(pl_rd)
    );

    trws_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_sleep_ram (
        .aclk(aclk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd),
        .raddr(sl_ra), .rdata(sl_rd)
    );

    assign s_ready  = (state_reg == trws_pkg::S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Result as it would be reported with the current ring state.
    always_comb begin
        rv  = (rcnt_reg != '0);
        rid = rv ? rh_reg : '0;
        new_res.status         = e_status_reg;
        new_res.running_valid  = rv;
        new_res.running_id     = 5'(rid);
        new_res.switched       = (rv != prev_v_reg) || (rid != prev_id_reg);
        new_res.created_id     = 5'(e_created_reg);
        new_res.woken_valid    = e_wv_reg;
        new_res.woken_id       = 5'(e_wid_reg);
        new_res.delivered_char = e_ch_reg;
        new_res.ready_count    = 6'(rcnt_reg);
        new_res.waiting_count  = 6'(wcnt_reg);
        new_res.last_result    = 1'b0;
    end

    always_comb begin
        state_next    = state_reg;
        rh_next       = rh_reg;
        rt_next       = rt_reg;
        wh_next       = wh_reg;
        wt_next       = wt_reg;
        rcnt_next     = rcnt_reg;
        wcnt_next     = wcnt_reg;
        busy_next     = busy_reg;
        cur_next      = cur_reg;
        nx_next       = nx_reg;
        idx_next      = idx_reg;
        lim_next      = lim_reg;
        due_next      = due_reg;
        woke_next     = woke_reg;
        in_sweep_next = in_sweep_reg;
        op_next       = op_reg;
        ticks_next    = ticks_reg;
        ch_next       = ch_reg;
        e_status_next = e_status_reg;
        e_created_next = e_created_reg;
        e_wv_next     = e_wv_reg;
        e_wid_next    = e_wid_reg;
        e_ch_next     = e_ch_reg;
        prev_v_next   = prev_v_reg;
        prev_id_next  = prev_id_reg;
        sent_next     = sent_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        nl_we = 1'b0;
        nl_wa = cur_reg;
        nl_wd = cur_reg;
        pl_we = 1'b0;
        pl_wa = cur_reg;
        pl_wd = cur_reg;
        sl_we = 1'b0;
        sl_wa = cur_reg;
        sl_wd = '0;
        nl_ra = cur_reg;
        pl_ra = cur_reg;
        sl_ra = cur_reg;

        unique case (state_reg)
            trws_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next        = s_func;
                    ticks_next     = s_sleep_ticks;
                    ch_next        = s_char_value;
                    sent_next      = '0;
                    pend_v_next    = 1'b0;
                    in_sweep_next  = 1'b0;
                    prev_v_next    = (rcnt_reg != '0);
                    prev_id_next   = (rcnt_reg != '0) ? rh_reg : '0;
                    e_status_next  = trws_pkg::ST_OK;
                    e_created_next = '0;
                    e_wv_next      = 1'b0;
                    e_wid_next     = '0;
                    e_ch_next      = '0;
                    idx_next       = '0;
                    unique case (s_func)
                        trws_pkg::FUNC_CREATE: state_next = trws_pkg::S_CR;
                        trws_pkg::FUNC_TICK:   state_next = trws_pkg::S_T0;
                        trws_pkg::FUNC_WAIT: begin
                            if (rcnt_reg == '0) begin
                                e_status_next = trws_pkg::ST_NO_RUN;
                                state_next    = trws_pkg::S_EM;
                            end else begin
                                cur_next   = rh_reg;
                                state_next = trws_pkg::S_O0;
                            end
                        end
                        trws_pkg::FUNC_KILL: begin
                            if (rcnt_reg == '0) begin
                                e_status_next = trws_pkg::ST_NO_RUN;
                                state_next    = trws_pkg::S_EM;
                            end else if (rcnt_reg == CW'(1)) begin
                                busy_next[rh_reg] = 1'b0;
                                cur_next   = wh_reg;
                                due_next   = 1'b0;
                                state_next = trws_pkg::S_KS1;
                            end else begin
                                busy_next[rh_reg] = 1'b0;
                                cur_next   = rh_reg;
                                state_next = trws_pkg::S_O0;
                            end
                        end
                        trws_pkg::FUNC_CHAR: begin
                            cur_next   = wh_reg;
                            state_next = trws_pkg::S_C1;
                        end
                        default: state_next = trws_pkg::S_EM;
                    endcase
                end
            end

            // Lowest free slot, one in-use bit per cycle.
            trws_pkg::S_CR: begin
                if (idx_reg == CW'(SLOTS)) begin
                    e_status_next = trws_pkg::ST_NO_SLOT;
                    state_next    = trws_pkg::S_EM;
                end else if (!busy_reg[idx_reg[LW-1:0]]) begin
                    busy_next[idx_reg[LW-1:0]] = 1'b1;
                    cur_next       = idx_reg[LW-1:0];
                    e_created_next = idx_reg[LW-1:0];
                    state_next     = trws_pkg::S_P0;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            // Remove the running thread from the ready ring.
            trws_pkg::S_O0: begin
                if (rcnt_reg > CW'(1)) begin
                    nl_ra      = rh_reg;
                    pl_ra      = rh_reg;
                    state_next = trws_pkg::S_O1;
                end else begin
                    rcnt_next  = rcnt_reg - CW'(1);
                    state_next = (op_reg == trws_pkg::FUNC_WAIT) ? trws_pkg::S_WT0
                                                                 : trws_pkg::S_EM;
                end
            end

            trws_pkg::S_O1: begin
                pl_we = 1'b1;
                pl_wa = nl_rd;
                pl_wd = pl_rd;
                nl_we = 1'b1;
                nl_wa = pl_rd;
                nl_wd = nl_rd;
                rh_next = nl_rd;
                if (cur_reg == rt_reg) begin
                    rt_next = pl_rd;
                end
                rcnt_next  = rcnt_reg - CW'(1);
                state_next = (op_reg == trws_pkg::FUNC_WAIT) ? trws_pkg::S_WT0
                                                             : trws_pkg::S_EM;
            end

            // Append the popped thread to the waiting tail.
            trws_pkg::S_WT0: begin
                sl_we = 1'b1;
                sl_wd = ticks_reg;
                if (wcnt_reg == '0) begin
                    nl_we      = 1'b1;
                    pl_we      = 1'b1;
                    wh_next    = cur_reg;
                    wt_next    = cur_reg;
                    wcnt_next  = wcnt_reg + CW'(1);
                    state_next = trws_pkg::S_EM;
                end else begin
                    nl_we      = 1'b1;
                    nl_wa      = wt_reg;
                    pl_we      = 1'b1;
                    pl_wd      = wt_reg;
                    state_next = trws_pkg::S_WT1;
                end
            end

            trws_pkg::S_WT1: begin
                nl_we      = 1'b1;
                nl_wd      = wh_reg;
                pl_we      = 1'b1;
                pl_wa      = wh_reg;
                wt_next    = cur_reg;
                wcnt_next  = wcnt_reg + CW'(1);
                state_next = trws_pkg::S_EM;
            end

            // Kill of the last ready thread: look for any thread due now.
            trws_pkg::S_KS1: begin
                if (idx_reg >= wcnt_reg) begin
                    state_next = trws_pkg::S_KS3;
                end else begin
                    state_next = trws_pkg::S_KS2;
                end
            end

            trws_pkg::S_KS2: begin
                if (sl_rd == SW'(1)) begin
                    due_next = 1'b1;
                end
                cur_next   = nl_rd;
                idx_next   = idx_reg + CW'(1);
                state_next = trws_pkg::S_KS1;
            end

            trws_pkg::S_KS3: begin
                rcnt_next  = '0;
                state_next = due_reg ? trws_pkg::S_SW0 : trws_pkg::S_EM;
            end

            // Rotation of the ready ring.
            trws_pkg::S_T0: begin
                if (rcnt_reg > CW'(1)) begin
                    nl_ra      = rh_reg;
                    state_next = trws_pkg::S_T1;
                end else begin
                    state_next = trws_pkg::S_SW0;
                end
            end

            trws_pkg::S_T1: begin
                rh_next    = nl_rd;
                pl_ra      = nl_rd;
                state_next = trws_pkg::S_T2;
            end

            trws_pkg::S_T2: begin
                rt_next    = pl_rd;
                state_next = trws_pkg::S_SW0;
            end

            // Walk of the waiting ring.
            trws_pkg::S_SW0: begin
                lim_next      = wcnt_reg;
                cur_next      = wh_reg;
                idx_next      = '0;
                woke_next     = 1'b0;
                in_sweep_next = 1'b1;
                state_next    = trws_pkg::S_SW1;
            end

            trws_pkg::S_SW1: begin
                if (idx_reg >= lim_reg) begin
                    state_next = trws_pkg::S_SWEND;
                end else begin
                    state_next = trws_pkg::S_SW2;
                end
            end

            trws_pkg::S_SW2: begin
                if (sl_rd > SW'(1)) begin
                    sl_we      = 1'b1;
                    sl_wd      = sl_rd - SW'(1);
                    cur_next   = nl_rd;
                    idx_next   = idx_reg + CW'(1);
                    state_next = trws_pkg::S_SW1;
                end else if (sl_rd == SW'(1)) begin
                    nx_next    = nl_rd;
                    woke_next  = 1'b1;
                    e_wv_next  = 1'b1;
                    e_wid_next = cur_reg;
                    state_next = trws_pkg::S_W0;
                end else begin
                    cur_next   = nl_rd;
                    idx_next   = idx_reg + CW'(1);
                    state_next = trws_pkg::S_SW1;
                end
            end

            trws_pkg::S_SWN: begin
                cur_next   = nx_reg;
                idx_next   = idx_reg + CW'(1);
                state_next = trws_pkg::S_SW1;
            end

            trws_pkg::S_SWEND: begin
                in_sweep_next = 1'b0;
                state_next    = woke_reg ? trws_pkg::S_FIN : trws_pkg::S_EM;
            end

            // First thread waiting for a character.
            trws_pkg::S_C1: begin
                if (idx_reg >= wcnt_reg) begin
                    e_status_next = trws_pkg::ST_NO_CHAR;
                    state_next    = trws_pkg::S_EM;
                end else begin
                    state_next = trws_pkg::S_C2;
                end
            end

            trws_pkg::S_C2: begin
                if (sl_rd == '0) begin
                    e_wv_next  = 1'b1;
                    e_wid_next = cur_reg;
                    e_ch_next  = (ch_reg == trws_pkg::NO_CHAR) ? 8'd0 : ch_reg;
                    state_next = trws_pkg::S_W0;
                end else begin
                    cur_next   = nl_rd;
                    idx_next   = idx_reg + CW'(1);
                    state_next = trws_pkg::S_C1;
                end
            end

            // Unlink a woken thread from the waiting ring.
            trws_pkg::S_W0: begin
                if (wcnt_reg > CW'(1)) begin
                    state_next = trws_pkg::S_W1;
                end else begin
                    if (wcnt_reg != '0) begin
                        wcnt_next = wcnt_reg - CW'(1);
                    end
                    state_next = trws_pkg::S_P0;
                end
            end

            trws_pkg::S_W1: begin
                pl_we = 1'b1;
                pl_wa = nl_rd;
                pl_wd = pl_rd;
                nl_we = 1'b1;
                nl_wa = pl_rd;
                nl_wd = nl_rd;
                if (cur_reg == wh_reg) begin
                    wh_next = nl_rd;
                end
                if (cur_reg == wt_reg) begin
                    wt_next = pl_rd;
                end
                wcnt_next  = wcnt_reg - CW'(1);
                state_next = trws_pkg::S_P0;
            end

            // Insert into the ready ring: tick wakes go to the tail, all
            // others right after the running thread.
            trws_pkg::S_P0: begin
                sl_we = 1'b1;
                if (rcnt_reg == '0) begin
                    nl_we      = 1'b1;
                    pl_we      = 1'b1;
                    rh_next    = cur_reg;
                    rt_next    = cur_reg;
                    rcnt_next  = rcnt_reg + CW'(1);
                    state_next = trws_pkg::S_EM;
                end else if (rcnt_reg == CW'(1)) begin
                    nl_we      = 1'b1;
                    nl_wa      = rh_reg;
                    pl_we      = 1'b1;
                    pl_wa      = rh_reg;
                    state_next = trws_pkg::S_P1;
                end else if (in_sweep_reg) begin
                    nl_we      = 1'b1;
                    nl_wa      = rt_reg;
                    pl_we      = 1'b1;
                    pl_wd      = rt_reg;
                    state_next = trws_pkg::S_P3;
                end else begin
                    nl_ra      = rh_reg;
                    state_next = trws_pkg::S_P2;
                end
            end

            trws_pkg::S_P1: begin
                nl_we      = 1'b1;
                nl_wd      = rh_reg;
                pl_we      = 1'b1;
                pl_wd      = rh_reg;
                rt_next    = cur_reg;
                rcnt_next  = rcnt_reg + CW'(1);
                state_next = trws_pkg::S_EM;
            end

            trws_pkg::S_P2: begin
                pl_we      = 1'b1;
                pl_wa      = nl_rd;
                nl_we      = 1'b1;
                nl_wd      = nl_rd;
                state_next = trws_pkg::S_P4;
            end

            trws_pkg::S_P4: begin
                nl_we      = 1'b1;
                nl_wa      = rh_reg;
                pl_we      = 1'b1;
                pl_wd      = rh_reg;
                rcnt_next  = rcnt_reg + CW'(1);
                state_next = trws_pkg::S_EM;
            end

            trws_pkg::S_P3: begin
                nl_we      = 1'b1;
                nl_wd      = rh_reg;
                pl_we      = 1'b1;
                pl_wa      = rh_reg;
                rt_next    = cur_reg;
                rcnt_next  = rcnt_reg + CW'(1);
                state_next = trws_pkg::S_EM;
            end

            // The older pending result leaves once a newer one exists; past
            // the result cap the newest one overwrites the pending slot.
            trws_pkg::S_EM: begin
                if (!(pend_v_reg && sent_reg < SENT_CAP && !out_free)) begin
                    if (pend_v_reg && sent_reg < SENT_CAP) begin
                        out_next     = pend_reg;
                        m_valid_next = 1'b1;
                        sent_next    = sent_reg + trws_pkg::SENT_W'(1);
                    end
                    pend_next    = new_res;
                    pend_v_next  = 1'b1;
                    prev_v_next  = rv;
                    prev_id_next = rid;
                    state_next   = in_sweep_reg ? trws_pkg::S_SWN : trws_pkg::S_FIN;
                end
            end

            trws_pkg::S_FIN: begin
                if (out_free) begin
                    out_next             = pend_reg;
                    out_next.last_result = 1'b1;
                    m_valid_next         = 1'b1;
                    pend_v_next          = 1'b0;
                    state_next           = trws_pkg::S_IDLE;
                end
            end

            default: state_next = trws_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= trws_pkg::S_IDLE;
            rh_reg       <= '0;
            rt_reg       <= '0;
            wh_reg       <= '0;
            wt_reg       <= '0;
            rcnt_reg     <= '0;
            wcnt_reg     <= '0;
            busy_reg     <= '0;
            in_sweep_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rh_reg       <= rh_next;
            rt_reg       <= rt_next;
            wh_reg       <= wh_next;
            wt_reg       <= wt_next;
            rcnt_reg     <= rcnt_next;
            wcnt_reg     <= wcnt_next;
            busy_reg     <= busy_next;
            in_sweep_reg <= in_sweep_next;
            pend_v_reg   <= pend_v_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        nx_reg        <= nx_next;
        idx_reg       <= idx_next;
        lim_reg       <= lim_next;
        due_reg       <= due_next;
        woke_reg      <= woke_next;
        op_reg        <= op_next;
        ticks_reg     <= ticks_next;
        ch_reg        <= ch_next;
        e_status_reg  <= e_status_next;
        e_created_reg <= e_created_next;
        e_wv_reg      <= e_wv_next;
        e_wid_reg     <= e_wid_next;
        e_ch_reg      <= e_ch_next;
        prev_v_reg    <= prev_v_next;
        prev_id_reg   <= prev_id_next;
        sent_reg      <= sent_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_running_valid  = out_reg.running_valid;
    assign m_running_id     = out_reg.running_id;
    assign m_switched       = out_reg.switched;
    assign m_created_id     = out_reg.created_id;
    assign m_woken_valid    = out_reg.woken_valid;
    assign m_woken_id       = out_reg.woken_id;
    assign m_delivered_char = out_reg.delivered_char;
    assign m_ready_count    = out_reg.ready_count;
    assign m_waiting_count  = out_reg.waiting_count;
    assign m_last_result    = out_reg.last_result;

    assign ring_sum = {1'b0, rcnt_reg} + {1'b0, wcnt_reg};

`include "thread_ready_wait_scheduler_assert.svh"

    // The two rings together hold no more threads than there are slots.
    `TRWS_ASSERT_ALWAYS(a_ring_sum, aclk, aresetn, ring_sum <= (CW + 1)'(SLOTS))
    // No result of a finished event is left behind when a new one is taken.
    `TRWS_ASSERT_IMPLY(a_idle_drained, aclk, aresetn, s_ready, !pend_v_reg)
    // Between events the running thread holds an allocated slot.
    `TRWS_ASSERT_IMPLY(a_run_busy, aclk, aresetn, s_ready && rcnt_reg != '0, busy_reg[rh_reg])

endmodule

@@ verif/thread_ready_wait_scheduler_test.sv @@
// ----------------------------------------------------------------------------
// Thread scheduler testbench
// Drives scheduler events (create, tick, wait, kill, character) through the
// input channel under several idle and stall patterns, predicts every result
// with a behavioral model of the rings and compares each result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thread_ready_wait_scheduler_test;

    localparam int          NSLOT          = 32;
    localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;

    // Behavioral model of the scheduler plus the queue of pending results.
    class sched_scoreboard;
        int         nxt[NSLOT];
        int         prv[NSLOT];
        logic [15:0] sleep_cnt[NSLOT];
        bit         busy[NSLOT];
        int         rhead, rtail, rtot, whead, wtail, wtot;
        bit         pv;
        int         pid;
        int         n_res;
        trws_pkg::result_t expected_q[$];
        int         errors;
        int         checked;

        function new();
            foreach (nxt[i]) begin
                nxt[i] = 0;
                prv[i] = 0;
                sleep_cnt[i] = '0;
                busy[i] = 0;
            end
            rhead = 0; rtail = 0; rtot = 0;
            whead = 0; wtail = 0; wtot = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void emit(logic [1:0] st, int created, bit wv, int wid, logic [7:0] ch);
            trws_pkg::result_t r;
            bit rv;
            int rid;
            rv = rtot > 0;
            rid = rv ? rhead : 0;
            r.status = st;
            r.running_valid = rv;
            r.running_id = 5'(rid);
            r.switched = (rv != pv) || (rid != pid);
            r.created_id = 5'(created);
            r.woken_valid = wv;
            r.woken_id = 5'(wid);
            r.delivered_char = ch;
            r.ready_count = 6'(rtot);
            r.waiting_count = 6'(wtot);
            r.last_result = 1'b0;
            pv = rv;
            pid = rid;
            if (n_res < trws_pkg::MAX_RESULTS) begin
                expected_q.push_back(r);
                n_res++;
            end else begin
                expected_q[expected_q.size() - 1] = r;
            end
        endfunction

        function void push_ready(int id);
            int h, n;
            if (rtot == 0) begin
                rhead = id; rtail = id;
                nxt[id] = id; prv[id] = id;
            end else if (rtot == 1) begin
                nxt[rhead] = id; prv[rhead] = id;
                nxt[id] = rhead; prv[id] = rhead;
                rtail = id;
            end else if (sleep_cnt[id] == 0) begin
                // A fresh or character-woken thread runs right after the current one.
                h = rhead;
                n = nxt[h];
                prv[n] = id;
                nxt[id] = n;
                nxt[h] = id;
                prv[id] = h;
            end else begin
                nxt[rtail] = id; prv[id] = rtail;
                nxt[id] = rhead; prv[rhead] = id;
                rtail = id;
            end
            rtot++;
            sleep_cnt[id] = '0;
        endfunction

        function void wake(int id);
            int n, p;
            if (wtot > 1) begin
                n = nxt[id];
                p = prv[id];
                prv[n] = p;
                nxt[p] = n;
                if (id == whead) whead = n;
                if (id == wtail) wtail = p;
            end
            if (wtot > 0) wtot--;
            push_ready(id);
        endfunction

        function int pop_running();
            int id, n, p;
            id = rhead;
            if (rtot > 1) begin
                n = nxt[id];
                p = prv[id];
                prv[n] = p;
                nxt[p] = n;
                rhead = n;
                if (id == rtail) rtail = p;
            end
            rtot--;
            return id;
        endfunction

        function int tick_sweep();
            int cnt, cur, nx, wakes;
            cnt = wtot;
            cur = whead;
            wakes = 0;
            if (rtot > 1) begin
                rhead = nxt[rhead];
                rtail = prv[rhead];
            end
            for (int i = 0; i < cnt && i < NSLOT; i++) begin
                nx = nxt[cur];
                if (sleep_cnt[cur] > 1) begin
                    sleep_cnt[cur]--;
                end else if (sleep_cnt[cur] == 1) begin
                    wake(cur);
                    emit(trws_pkg::ST_OK, 0, 1, cur, 8'd0);
                    wakes++;
                end
                cur = nx;
            end
            return wakes;
        endfunction

        function void note_event(logic [2:0] func, logic [15:0] ticks, logic [7:0] ch);
            int slot, id, cur, found;
            bit due;
            n_res = 0;
            pv = rtot > 0;
            pid = pv ? rhead : 0;
            case (func)
                trws_pkg::FUNC_CREATE: begin
                    slot = NSLOT;
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!busy[i]) slot = i;
                    if (slot == NSLOT) begin
                        emit(trws_pkg::ST_NO_SLOT, 0, 0, 0, 8'd0);
                    end else begin
                        busy[slot] = 1;
                        sleep_cnt[slot] = '0;
                        push_ready(slot);
                        emit(trws_pkg::ST_OK, slot, 0, 0, 8'd0);
                    end
                end
                trws_pkg::FUNC_TICK: begin
                    if (tick_sweep() == 0) emit(trws_pkg::ST_OK, 0, 0, 0, 8'd0);
                end
                trws_pkg::FUNC_WAIT: begin
                    if (rtot == 0) begin
                        emit(trws_pkg::ST_NO_RUN, 0, 0, 0, 8'd0);
                    end else begin
                        id = pop_running();
                        sleep_cnt[id] = ticks;
                        if (wtot == 0) begin
                            whead = id; wtail = id;
                            nxt[id] = id; prv[id] = id;
                        end else begin
                            nxt[wtail] = id; prv[id] = wtail;
                            nxt[id] = whead; prv[whead] = id;
                            wtail = id;
                        end
                        wtot++;
                        emit(trws_pkg::ST_OK, 0, 0, 0, 8'd0);
                    end
                end
                trws_pkg::FUNC_KILL: begin
                    if (rtot == 0) begin
                        emit(trws_pkg::ST_NO_RUN, 0, 0, 0, 8'd0);
                    end else if (rtot == 1) begin
                        // Killing the last ready thread runs a sweep if a sleeper is due.
                        cur = whead;
                        due = 0;
                        busy[rhead] = 0;
                        for (int i = 0; i < wtot && i < NSLOT; i++) begin
                            if (sleep_cnt[cur] == 1) due = 1;
                            cur = nxt[cur];
                        end
                        rtot = 0;
                        if (!due || tick_sweep() == 0) emit(trws_pkg::ST_OK, 0, 0, 0, 8'd0);
                    end else begin
                        busy[rhead] = 0;
                        void'(pop_running());
                        emit(trws_pkg::ST_OK, 0, 0, 0, 8'd0);
                    end
                end
                trws_pkg::FUNC_CHAR: begin
                    cur = whead;
                    found = NSLOT;
                    for (int i = 0; i < wtot && i < NSLOT; i++) begin
                        if (sleep_cnt[cur] == 0) begin
                            found = cur;
                            break;
                        end
                        cur = nxt[cur];
                    end
                    if (found == NSLOT) begin
                        emit(trws_pkg::ST_NO_CHAR, 0, 0, 0, 8'd0);
                    end else begin
                        wake(found);
                        emit(trws_pkg::ST_OK, 0, 1, found,
                             (ch != trws_pkg::NO_CHAR) ? ch : 8'd0);
                    end
                end
                default: emit(trws_pkg::ST_OK, 0, 0, 0, 8'd0);
            endcase
            expected_q[expected_q.size() - 1].last_result = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(trws_pkg::result_t got);
            trws_pkg::result_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                exp = expected_q.pop_front();
                checked++;
                if (got !== exp)
                    report_mismatch($sformatf("got %p expected %p", got, exp));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [15:0] s_sleep_ticks;
    logic [7:0]  s_char_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_running_valid;
    logic [4:0]  m_running_id;
    logic        m_switched;
    logic [4:0]  m_created_id;
    logic        m_woken_valid;
    logic [4:0]  m_woken_id;
    logic [7:0]  m_delivered_char;
    logic [5:0]  m_ready_count;
    logic [5:0]  m_waiting_count;
    logic        m_last_result;

    sched_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    int quiet;
    int hold_cycles;
    int events_sent;
    int func_seen[8];

    thread_ready_wait_scheduler dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_sleep_ticks   (s_sleep_ticks),
        .s_char_value    (s_char_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_running_valid (m_running_valid),
        .m_running_id    (m_running_id),
        .m_switched      (m_switched),
        .m_created_id    (m_created_id),
        .m_woken_valid   (m_woken_valid),
        .m_woken_id      (m_woken_id),
        .m_delivered_char(m_delivered_char),
        .m_ready_count   (m_ready_count),
        .m_waiting_count (m_waiting_count),
        .m_last_result   (m_last_result)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #8ms;
        $display("thread_ready_wait_scheduler test failed");
        $finish;
    end

    // Receiver: a long hold-off when requested, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (quiet == 0 && $urandom_range(99) < stall_pct) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_running_valid, m_running_id, m_switched,
                             m_created_id, m_woken_valid, m_woken_id, m_delivered_char,
                             m_ready_count, m_waiting_count, m_last_result});
    end

    task send_event(logic [2:0] func, logic [15:0] ticks, logic [7:0] ch);
        @(negedge aclk);
        s_valid = 1'b1;
        s_func = func;
        s_sleep_ticks = ticks;
        s_char_value = ch;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(func, ticks, ch);
        events_sent++;
        func_seen[func]++;
        if (quiet > 0) begin
            quiet--;
        end else if ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(5)) @(negedge aclk);
        end
    endtask

    function logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 16'd0;
        if (r < 85) return 16'($urandom_range(1, 4));
        if (r < 95) return 16'($urandom_range(5, 40));
        if (r < 99) return 16'($urandom);
        return 16'hFFFF;
    endfunction

    task random_event();
        int r;
        logic [7:0] ch;
        r = $urandom_range(99);
        ch = ($urandom_range(9) == 0) ? trws_pkg::NO_CHAR : 8'($urandom);
        if (r < 22)      send_event(trws_pkg::FUNC_CREATE, 16'($urandom), ch);
        else if (r < 50) send_event(trws_pkg::FUNC_TICK, 16'($urandom), ch);
        else if (r < 72) send_event(trws_pkg::FUNC_WAIT, pick_ticks(), ch);
        else if (r < 84) send_event(trws_pkg::FUNC_KILL, 16'($urandom), ch);
        else if (r < 96) send_event(trws_pkg::FUNC_CHAR, 16'($urandom), ch);
        else send_event(3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)), 16'($urandom), ch);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = trws_pkg::FUNC_CREATE;
        s_sleep_ticks = '0;
        s_char_value = '0;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet = 0;
        hold_cycles = 0;
        events_sent = 0;
        foreach (func_seen[i]) func_seen[i] = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-ring errors, both wait kinds, the no-character marker,
        // a kill of the last ready thread with a due sleeper, unused codes.
        send_event(trws_pkg::FUNC_WAIT, 16'd3, 8'd0);
        send_event(trws_pkg::FUNC_KILL, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_CHAR, 16'd0, 8'hFF);
        send_event(trws_pkg::FUNC_TICK, 16'hFFFF, 8'd0);
        send_event(trws_pkg::FUNC_CREATE, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_CREATE, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_CREATE, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_CREATE, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_WAIT, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_WAIT, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_WAIT, 16'd2, 8'd0);
        send_event(trws_pkg::FUNC_CHAR, 16'd0, 8'hFF);
        send_event(trws_pkg::FUNC_CHAR, 16'd0, trws_pkg::NO_CHAR);
        send_event(trws_pkg::FUNC_WAIT, 16'hFFFF, 8'd0);
        send_event(trws_pkg::FUNC_TICK, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_WAIT, 16'd1, 8'd0);
        send_event(trws_pkg::FUNC_KILL, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_TICK, 16'd0, 8'd0);
        send_event(trws_pkg::FUNC_KILL, 16'd0, 8'd0);
        send_event(FUNC_UNUSED_LO, 16'hFFFF, 8'hFF);
        send_event(3'd6, 16'h5555, 8'hAA);
        send_event(FUNC_UNUSED_HI, 16'hAAAA, 8'h55);
        send_event(trws_pkg::FUNC_KILL, 16'd0, 8'd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            quiet = 12;
            // The receiver holds off while the sender keeps offering events.
            if (ph == 0) hold_cycles = 400;
            // Once, fill every slot so that a create finds none free.
            if (ph == 1) begin
                repeat (NSLOT + 2) send_event(trws_pkg::FUNC_CREATE, 16'd0, 8'd0);
                repeat (20) send_event(trws_pkg::FUNC_KILL, 16'd0, 8'd0);
            end
            repeat (100) random_event();
        end
        @(negedge aclk);
        s_valid = 1'b0;

        wait (sb.expected_q.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Covered %0d events (create %0d, tick %0d, wait %0d, kill %0d, char %0d).",
                 events_sent, func_seen[0], func_seen[1], func_seen[2], func_seen[3],
                 func_seen[4]);
        $display("Checked %0d result transactions, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("thread_ready_wait_scheduler test passed");
        else
            $display("thread_ready_wait_scheduler test failed");
        $finish;
    end

endmodule
